>>> sv/pab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_pkg
// shared types and constants of the palette alpha blend pixel unit
// ----------------------------------------------------------------------------
package pab_pkg;

    localparam int OPCODE_W  = 2;
    localparam int PIXEL_W   = 8;
    localparam int COUNT_W   = 3;
    localparam int ALPHA_W   = 8;
    localparam int ADDR_W    = 15;
    localparam int DATA_W    = 24;
    localparam int PATH_W    = 2;
    localparam int CHAN_W    = 8;
    localparam int NUM_MASKS = 4;

    // blend weight of the first pixel at full coverage
    localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'h80;

    // weighted channel sums stay below 2^15
    localparam int SUM_W   = 16;
    localparam int SUM_MSB = 14;

    typedef enum logic [OPCODE_W-1:0] {
        OP_BLEND   = 2'd0,
        OP_PALETTE = 2'd1,
        OP_MAP     = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [PATH_W-1:0] {
        PATH_FIRST  = 2'd0,
        PATH_SECOND = 2'd1,
        PATH_MIXED  = 2'd2
    } path_t;

endpackage

>>> sv/pab_job_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_job_if
// input channel: blend requests and table write operations
// ----------------------------------------------------------------------------
interface pab_job_if;
    logic                           valid;
    logic                           ready;
    logic [pab_pkg::OPCODE_W-1:0]   opcode;
    logic [pab_pkg::PIXEL_W-1:0]    first_pixel;
    logic [pab_pkg::PIXEL_W-1:0]    second_pixel;
    logic [pab_pkg::COUNT_W-1:0]    mask_count;
    logic [pab_pkg::ALPHA_W-1:0]    mask_alpha_0;
    logic [pab_pkg::ALPHA_W-1:0]    mask_alpha_1;
    logic [pab_pkg::ALPHA_W-1:0]    mask_alpha_2;
    logic [pab_pkg::ALPHA_W-1:0]    mask_alpha_3;
    logic [pab_pkg::ADDR_W-1:0]     table_address;
    logic [pab_pkg::DATA_W-1:0]     table_data;

    modport source (
        output valid, opcode, first_pixel, second_pixel, mask_count,
               mask_alpha_0, mask_alpha_1, mask_alpha_2, mask_alpha_3,
               table_address, table_data,
        input  ready
    );

    modport sink (
        input  valid, opcode, first_pixel, second_pixel, mask_count,
               mask_alpha_0, mask_alpha_1, mask_alpha_2, mask_alpha_3,
               table_address, table_data,
        output ready
    );
endinterface

>>> sv/pab_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_result_if
// output channel: blended pixel index and the path that produced it
// ----------------------------------------------------------------------------
interface pab_result_if;
    logic                           valid;
    logic                           ready;
    logic [pab_pkg::PIXEL_W-1:0]    out_pixel;
    logic [pab_pkg::PATH_W-1:0]     blend_path;

    modport source (
        output valid, out_pixel, blend_path,
        input  ready
    );

    modport sink (
        input  valid, out_pixel, blend_path,
        output ready
    );
endinterface

>>> sv/pab_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_mix
// weights two palette colors per channel and packs the color map address
// ----------------------------------------------------------------------------
module pab_mix #(
    parameter int MAP_CHANNEL_BITS = 5
) (
    input  logic [pab_pkg::DATA_W-1:0]      color_1,
    input  logic [pab_pkg::DATA_W-1:0]      color_2,
    input  logic                            color_1_ok,
    input  logic                            color_2_ok,
    input  logic [pab_pkg::ALPHA_W-1:0]     alpha,
    output logic [3*MAP_CHANNEL_BITS-1:0]   map_addr
);

    logic [pab_pkg::ALPHA_W-1:0] weight_2;

    assign weight_2 = pab_pkg::FULL_ALPHA - alpha;

    // blue in the low field, red in the high field, same as the color word
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [pab_pkg::CHAN_W-1:0] chan_1;
        logic [pab_pkg::CHAN_W-1:0] chan_2;
        logic [pab_pkg::SUM_W-1:0]  prod_1;
        logic [pab_pkg::SUM_W-1:0]  prod_2;
        logic [pab_pkg::SUM_W-1:0]  sum;

        // pixel beyond the palette reads as black
        assign chan_1 = color_1_ok ? color_1[c*pab_pkg::CHAN_W +: pab_pkg::CHAN_W] : '0;
        assign chan_2 = color_2_ok ? color_2[c*pab_pkg::CHAN_W +: pab_pkg::CHAN_W] : '0;
        assign prod_1 = pab_pkg::SUM_W'(chan_1) * pab_pkg::SUM_W'(alpha);
        assign prod_2 = pab_pkg::SUM_W'(chan_2) * pab_pkg::SUM_W'(weight_2);
        assign sum    = prod_1 + prod_2;
        assign map_addr[c*MAP_CHANNEL_BITS +: MAP_CHANNEL_BITS] =
            sum[pab_pkg::SUM_MSB -: MAP_CHANNEL_BITS];
    end

endmodule

>>> sv/palette_alpha_blend_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_alpha_blend_pixel_unit
// alpha blend of two palette-indexed pixels through an inverse color map
// ----------------------------------------------------------------------------
//
//  channel   modport   carries
//  -------   -------   ---------------------------------------------------
//  job       sink      blend request, palette write or color map write
//  result    source    blended palette index and blend path, one per blend
//
//  one transaction per cycle sustained while the result channel is ready; a blend
//  result follows its job transaction through the palette read, then the color map read
//  both tables are synchronous memories; no clearing pass after reset,
//  reset only empties the two pipeline stages
//  stalls back up stage by stage, so empty stages still take new jobs
//  while a result waits on the result channel
//
module palette_alpha_blend_pixel_unit #(
    parameter int PALETTE_ENTRIES  = 256,
    parameter int MAP_CHANNEL_BITS = 5,
    parameter int MAX_MASKS        = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    pab_job_if.sink             job,
    pab_result_if.source        result
);

    localparam int PAL_AW     = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int MAP_AW     = 3 * MAP_CHANNEL_BITS;
    localparam int MAP_DEPTH  = 1 << MAP_AW;
    localparam int MASK_LIMIT = (MAX_MASKS < pab_pkg::NUM_MASKS) ? MAX_MASKS
                                                                 : pab_pkg::NUM_MASKS;

    // ------------------------------------------------------------------
    // stage enables: a stage moves when the one ahead is empty or moves
    // ------------------------------------------------------------------
    logic en_1;
    logic en_2;
    logic job_accept;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    pab_pkg::opcode_t               s1_op_reg;
    pab_pkg::path_t                 s1_path_reg;
    pab_pkg::path_t                 s1_path_next;
    logic [pab_pkg::ALPHA_W-1:0]    s1_alpha_reg;
    logic [pab_pkg::PIXEL_W-1:0]    s1_pixel_reg;
    logic                           s1_ok_1_reg;
    logic                           s1_ok_2_reg;
    logic [MAP_AW-1:0]              s1_map_addr_reg;
    logic [pab_pkg::PIXEL_W-1:0]    s1_map_data_reg;

    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    pab_pkg::path_t                 s2_path_reg;
    logic [pab_pkg::PIXEL_W-1:0]    s2_pixel_reg;

    assign en_2       = !s2_valid_reg || result.ready;
    assign en_1       = !s1_valid_reg || en_2;
    assign job.ready  = en_1;
    assign job_accept = job.valid && job.ready;

    // ------------------------------------------------------------------
    // decode and blend weight: least of full alpha and each active mask
    // ------------------------------------------------------------------
    pab_pkg::opcode_t               job_op;
    logic [pab_pkg::ALPHA_W-1:0]    mask_a [pab_pkg::NUM_MASKS];
    logic [pab_pkg::COUNT_W-1:0]    mask_used;
    logic [pab_pkg::ALPHA_W-1:0]    alpha;

    assign job_op    = pab_pkg::opcode_t'(job.opcode);
    assign mask_a[0] = job.mask_alpha_0;
    assign mask_a[1] = job.mask_alpha_1;
    assign mask_a[2] = job.mask_alpha_2;
    assign mask_a[3] = job.mask_alpha_3;

    // too many masks saturates to the usable count
    assign mask_used = (job.mask_count > pab_pkg::COUNT_W'(MASK_LIMIT))
                     ? pab_pkg::COUNT_W'(MASK_LIMIT) : job.mask_count;

    always_comb
    begin
        alpha = pab_pkg::FULL_ALPHA;
        for (int i = 0; i < pab_pkg::NUM_MASKS; i++)
        begin
            if ((pab_pkg::COUNT_W'(i) < mask_used) && (mask_a[i] < alpha))
            begin
                alpha = mask_a[i];
            end
        end
    end

    always_comb
    begin
        priority if (alpha == pab_pkg::FULL_ALPHA)
        begin
            s1_path_next = pab_pkg::PATH_FIRST;
        end
        else if (alpha == '0)
        begin
            s1_path_next = pab_pkg::PATH_SECOND;
        end
        else
        begin
            s1_path_next = pab_pkg::PATH_MIXED;
        end
    end

    // only blends and color map writes need the second stage
    assign s1_valid_next = job_accept
                        && ((job_op == pab_pkg::OP_BLEND) || (job_op == pab_pkg::OP_MAP));

    // ------------------------------------------------------------------
    // palette memory: written and read at job transaction time
    // ------------------------------------------------------------------
    logic [pab_pkg::DATA_W-1:0] pal_mem [PALETTE_ENTRIES];
    logic [pab_pkg::DATA_W-1:0] pal_rd_1_reg;
    logic [pab_pkg::DATA_W-1:0] pal_rd_2_reg;
    logic                       pal_we;
    logic                       ok_1;
    logic                       ok_2;

    // palette write out of range is dropped
    assign pal_we = job_accept && (job_op == pab_pkg::OP_PALETTE)
                 && (job.table_address < pab_pkg::ADDR_W'(PALETTE_ENTRIES));
    assign ok_1   = {1'b0, job.first_pixel}  < (pab_pkg::PIXEL_W + 1)'(PALETTE_ENTRIES);
    assign ok_2   = {1'b0, job.second_pixel} < (pab_pkg::PIXEL_W + 1)'(PALETTE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[job.table_address[PAL_AW-1:0]] <= job.table_data;
        end
        if (en_1)
        begin
            pal_rd_1_reg <= pal_mem[job.first_pixel[PAL_AW-1:0]];
            pal_rd_2_reg <= pal_mem[job.second_pixel[PAL_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // stage 1 registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en_1)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_1)
        begin
            s1_op_reg       <= job_op;
            s1_path_reg     <= s1_path_next;
            s1_alpha_reg    <= alpha;
            s1_pixel_reg    <= (s1_path_next == pab_pkg::PATH_FIRST) ? job.first_pixel
                                                                     : job.second_pixel;
            s1_ok_1_reg     <= ok_1;
            s1_ok_2_reg     <= ok_2;
            // color map address is masked (or zero-extended) to the map size
            s1_map_addr_reg <= MAP_AW'(job.table_address);
            s1_map_data_reg <= job.table_data[pab_pkg::PIXEL_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // channel mix from the palette read data
    // ------------------------------------------------------------------
    logic [MAP_AW-1:0] mix_addr;

    pab_mix #(
        .MAP_CHANNEL_BITS (MAP_CHANNEL_BITS)
    ) u_mix (
        .color_1    (pal_rd_1_reg),
        .color_2    (pal_rd_2_reg),
        .color_1_ok (s1_ok_1_reg),
        .color_2_ok (s1_ok_2_reg),
        .alpha      (s1_alpha_reg),
        .map_addr   (mix_addr)
    );

    // ------------------------------------------------------------------
    // color map memory: writes travel through stage 1 so that they stay
    // in order with the lookups of earlier blends
    // ------------------------------------------------------------------
    logic [pab_pkg::PIXEL_W-1:0] map_mem [MAP_DEPTH];
    logic [pab_pkg::PIXEL_W-1:0] map_rd_reg;
    logic                        map_we;

    assign map_we = en_2 && s1_valid_reg && (s1_op_reg == pab_pkg::OP_MAP);

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[s1_map_addr_reg] <= s1_map_data_reg;
        end
        if (en_2)
        begin
            map_rd_reg <= map_mem[mix_addr];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: output register
    // ------------------------------------------------------------------
    assign s2_valid_next = s1_valid_reg && (s1_op_reg == pab_pkg::OP_BLEND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en_2)
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_2)
        begin
            s2_path_reg  <= s1_path_reg;
            s2_pixel_reg <= s1_pixel_reg;
        end
    end

    assign result.valid      = s2_valid_reg;
    assign result.blend_path = s2_path_reg;
    assign result.out_pixel  = (s2_path_reg == pab_pkg::PATH_MIXED) ? map_rd_reg
                                                                    : s2_pixel_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted blend always lands in stage 1
    a_blend_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (job_accept && (job_op == pab_pkg::OP_BLEND))
        |=> (s1_valid_reg && (s1_op_reg == pab_pkg::OP_BLEND)))
        else $error("accepted blend missing from stage 1");

    // a color map write produces no result transaction
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        map_we |=> !s2_valid_reg)
        else $error("color map write produced a result");

    // mixing only happens with a partial weight
    a_mixed_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_op_reg == pab_pkg::OP_BLEND)
         && (s1_path_reg == pab_pkg::PATH_MIXED))
        |-> ((s1_alpha_reg != '0) && (s1_alpha_reg < pab_pkg::FULL_ALPHA)))
        else $error("mixed path with full or zero alpha");

endmodule
